// ----- hdl/uvs_pkg.sv -----
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and constants of the uv sphere cell vertex unit.
// ----------------------------------------------------------------------------
package uvs_pkg;

   localparam int RADIUS_W = 23;
   localparam int CNT_W    = 9;
   localparam int IDX_W    = 8;
   localparam int TRIG_W   = 32;
   localparam int TEX_W    = 17;
   localparam int POS_W    = 24;
   localparam int NRM_W    = 16;

   // restoring divider geometry: (k << 32) + bias over a count of up to 2*256
   localparam int DIV_NUM_W = 41;
   localparam int DIV_DEN_W = 10;

   localparam int CORDIC_GAIN = 652032874;
   localparam int ATAN_LEN    = 24;
   localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // corner order p1,p4,p2,p1,p3,p4: bit v gives polar (a) and azimuth (b) step
   localparam logic [5:0] CORNER_A = 6'b110010;
   localparam logic [5:0] CORNER_B = 6'b100110;
   localparam logic [2:0] VTX_LAST = 3'd5;

   typedef enum logic [1:0] {
      CSR_RADIUS = 2'd0,
      CSR_SLICES = 2'd1,
      CSR_STACKS = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [1:0][TRIG_W-1:0] th_c;
      logic [1:0][TRIG_W-1:0] th_s;
      logic [1:0][TRIG_W-1:0] ph_c;
      logic [1:0][TRIG_W-1:0] ph_s;
      logic [1:0][TEX_W-1:0]  tu;
      logic [1:0][TEX_W-1:0]  tv;
      logic                   err;
   } vtx_item_type;

endpackage

// ----- hdl/uvs_req_if.sv -----
// ----------------------------------------------------------------------------
// uvs_req_if
// Cell request channel: one grid cell per transfer.
// ----------------------------------------------------------------------------
interface uvs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] slice_index;
   logic [7:0] stack_index;

   modport source (output valid, output slice_index, output stack_index, input ready);
   modport sink (input valid, input slice_index, input stack_index, output ready);
endinterface

// ----- hdl/uvs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// uvs_rsp_if
// Vertex response channel: one vertex per transfer.
// ----------------------------------------------------------------------------
interface uvs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] pos_x;
   logic signed [23:0] pos_y;
   logic signed [23:0] pos_z;
   logic signed [15:0] norm_x;
   logic signed [15:0] norm_y;
   logic signed [15:0] norm_z;
   logic [16:0]        tex_u;
   logic [16:0]        tex_v;
   logic               last_vertex;
   logic               index_error;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output norm_x, output norm_y, output norm_z, output tex_u,
                   output tex_v, output last_vertex, output index_error, input ready);
   modport sink (input valid, input pos_x, input pos_y, input pos_z,
                 input norm_x, input norm_y, input norm_z, input tex_u,
                 input tex_v, input last_vertex, input index_error, output ready);
endinterface

// ----- hdl/uvs_div.sv -----
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module uvs_div #(
   parameter int NW = 41,
   parameter int DW = 10
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [NW-1:0] quo
);

   // each stage word: remainder on top, unused dividend bits and quotient below
   logic [DW+NW-1:0] rq_ff  [NW];
   logic [DW+NW-1:0] rq_in  [NW];
   logic [DW+NW-1:0] src    [NW];
   logic [DW:0]      trial  [NW];
   logic [DW:0]      rem    [NW];
   logic             ge     [NW];

   always_comb begin
      src[0] = {{DW{1'b0}}, num};
      for (int k = 1; k < NW; k++) begin
         src[k] = rq_ff[k-1];
      end
      for (int k = 0; k < NW; k++) begin
         trial[k] = src[k][DW+NW-1:NW-1];
         ge[k]    = (trial[k] >= {1'b0, den});
         rem[k]   = ge[k] ? (trial[k] - {1'b0, den}) : trial[k];
         rq_in[k] = {rem[k][DW-1:0], src[k][NW-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NW; k++) begin
            rq_ff[k] <= rq_in[k];
         end
      end
   end

   assign quo = rq_ff[NW-1][NW-1:0];

endmodule

// ----- hdl/uvs_cordic.sv -----
// ----------------------------------------------------------------------------
// uvs_cordic
// Pipelined rotation-mode cordic: binary angle in, cosine and sine in Q1.30.
// ----------------------------------------------------------------------------
module uvs_cordic #(
   parameter int STEPS = 16
) (
   input  logic               clock,
   input  logic               en,
   input  logic [31:0]        ang,
   output logic signed [31:0] cos_out,
   output logic signed [31:0] sin_out
);

   localparam int XW = 34;

   logic [31:0]          ang_sum;
   logic [1:0]           quad;
   logic [31:0]          resid;
   logic signed [XW-1:0] x_ff [STEPS+1];
   logic signed [XW-1:0] y_ff [STEPS+1];
   logic signed [XW-1:0] z_ff [STEPS+1];
   logic [1:0]           q_ff [STEPS+1];
   logic signed [XW-1:0] x_in [STEPS+1];
   logic signed [XW-1:0] y_in [STEPS+1];
   logic signed [XW-1:0] z_in [STEPS+1];
   logic [1:0]           q_in [STEPS+1];
   logic signed [31:0]   cos_ff;
   logic signed [31:0]   sin_ff;

   // fold to the nearest quarter turn, residual within an eighth turn
   assign ang_sum = ang + 32'h2000_0000;
   assign quad    = ang_sum[31:30];
   assign resid   = ang - {quad, 30'b0};

   always_comb begin
      x_in[0] = XW'(uvs_pkg::CORDIC_GAIN);
      y_in[0] = '0;
      z_in[0] = XW'($signed(resid));
      q_in[0] = quad;
      for (int k = 0; k < STEPS; k++) begin
         q_in[k+1] = q_ff[k];
         if (z_ff[k] >= 0) begin
            x_in[k+1] = x_ff[k] - (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] + (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] - XW'(uvs_pkg::ATAN_TURNS[k]);
         end else begin
            x_in[k+1] = x_ff[k] + (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] - (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] + XW'(uvs_pkg::ATAN_TURNS[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= STEPS; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
            q_ff[k] <= q_in[k];
         end
         case (q_ff[STEPS])
            2'd0: begin
               cos_ff <= x_ff[STEPS][31:0];
               sin_ff <= y_ff[STEPS][31:0];
            end
            2'd1: begin
               cos_ff <= 32'(-y_ff[STEPS]);
               sin_ff <= x_ff[STEPS][31:0];
            end
            2'd2: begin
               cos_ff <= 32'(-x_ff[STEPS]);
               sin_ff <= 32'(-y_ff[STEPS]);
            end
            default: begin
               cos_ff <= y_ff[STEPS][31:0];
               sin_ff <= 32'(-x_ff[STEPS]);
            end
         endcase
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// ----- hdl/uvs_vertex.sv -----
// ----------------------------------------------------------------------------
// uvs_vertex
// Walks the six corners of a cell and turns each into a vertex through a
// four-stage product, rounding and saturation pipeline.
// ----------------------------------------------------------------------------
module uvs_vertex (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ld_valid,
   output logic                   ld_ready,
   input  uvs_pkg::vtx_item_type  item,
   input  logic [22:0]            radius,
   uvs_rsp_if.source              rsp
);

   function automatic logic [15:0] nrm_round(input logic signed [31:0] d);
      logic signed [31:0] r;
      r = (d + 32'sd32768) >>> 16;
      if (r > 32'sd16384) r = 32'sd16384;
      else if (r < -32'sd16384) r = -32'sd16384;
      return r[15:0];
   endfunction

   function automatic logic [23:0] pos_round(input logic signed [55:0] p);
      logic signed [55:0] r;
      r = (p + 56'sd536870912) >>> 30;
      if (r > 56'sd8388607) r = 56'sd8388607;
      else if (r < -56'sd8388607) r = -56'sd8388607;
      return r[23:0];
   endfunction

   logic                  en_out;
   logic                  ser_last;
   logic                  ld;
   logic                  busy_ff;
   logic [2:0]            cnt_ff;
   uvs_pkg::vtx_item_type item_ff;
   logic                  sel_a;
   logic                  sel_b;
   logic signed [31:0]    ts, tc, ps, pc;
   logic signed [23:0]    rad_s;

   logic                  v1_vld_ff, v2_vld_ff, v3_vld_ff, v4_vld_ff;
   logic signed [63:0]    v1_px_ff, v1_pz_ff;
   logic signed [31:0]    v1_dy_ff;
   logic signed [31:0]    v2_dx_ff, v2_dy_ff, v2_dz_ff;
   logic signed [55:0]    v3_ppx_ff, v3_ppy_ff, v3_ppz_ff;
   logic [15:0]           v3_nx_ff, v3_ny_ff, v3_nz_ff;
   logic [23:0]           v4_px_ff, v4_py_ff, v4_pz_ff;
   logic [15:0]           v4_nx_ff, v4_ny_ff, v4_nz_ff;
   logic [16:0]           v1_tu_ff, v2_tu_ff, v3_tu_ff, v4_tu_ff;
   logic [16:0]           v1_tv_ff, v2_tv_ff, v3_tv_ff, v4_tv_ff;
   logic                  v1_last_ff, v2_last_ff, v3_last_ff, v4_last_ff;
   logic                  v1_err_ff, v2_err_ff, v3_err_ff, v4_err_ff;

   assign en_out   = !v4_vld_ff || rsp.ready;
   assign ser_last = (cnt_ff == uvs_pkg::VTX_LAST);
   assign ld_ready = !busy_ff || (ser_last && en_out);
   assign ld       = ld_valid && ld_ready;

   assign sel_a = uvs_pkg::CORNER_A[cnt_ff];
   assign sel_b = uvs_pkg::CORNER_B[cnt_ff];
   assign ts    = $signed(item_ff.th_s[sel_a]);
   assign tc    = $signed(item_ff.th_c[sel_a]);
   assign ps    = $signed(item_ff.ph_s[sel_b]);
   assign pc    = $signed(item_ff.ph_c[sel_b]);
   assign rad_s = $signed({1'b0, radius});

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         cnt_ff    <= '0;
         v1_vld_ff <= 1'b0;
         v2_vld_ff <= 1'b0;
         v3_vld_ff <= 1'b0;
         v4_vld_ff <= 1'b0;
      end else begin
         if (ld) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (en_out && busy_ff) begin
            if (ser_last) busy_ff <= 1'b0;
            else cnt_ff <= cnt_ff + 3'd1;
         end
         if (en_out) begin
            v1_vld_ff <= busy_ff;
            v2_vld_ff <= v1_vld_ff;
            v3_vld_ff <= v2_vld_ff;
            v4_vld_ff <= v3_vld_ff;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (ld) item_ff <= item;
      if (en_out) begin
         v1_px_ff   <= ts * ps;
         v1_pz_ff   <= ts * pc;
         v1_dy_ff   <= tc;
         v1_tu_ff   <= item_ff.tu[sel_b];
         v1_tv_ff   <= item_ff.tv[sel_a];
         v1_last_ff <= ser_last;
         v1_err_ff  <= item_ff.err;

         v2_dx_ff   <= 32'((v1_px_ff + 64'sd536870912) >>> 30);
         v2_dz_ff   <= 32'((v1_pz_ff + 64'sd536870912) >>> 30);
         v2_dy_ff   <= v1_dy_ff;
         v2_tu_ff   <= v1_tu_ff;
         v2_tv_ff   <= v1_tv_ff;
         v2_last_ff <= v1_last_ff;
         v2_err_ff  <= v1_err_ff;

         v3_ppx_ff  <= rad_s * v2_dx_ff;
         v3_ppy_ff  <= rad_s * v2_dy_ff;
         v3_ppz_ff  <= rad_s * v2_dz_ff;
         v3_nx_ff   <= nrm_round(v2_dx_ff);
         v3_ny_ff   <= nrm_round(v2_dy_ff);
         v3_nz_ff   <= nrm_round(v2_dz_ff);
         v3_tu_ff   <= v2_tu_ff;
         v3_tv_ff   <= v2_tv_ff;
         v3_last_ff <= v2_last_ff;
         v3_err_ff  <= v2_err_ff;

         // a bad index zeroes everything but the flags
         v4_px_ff   <= v3_err_ff ? '0 : pos_round(v3_ppx_ff);
         v4_py_ff   <= v3_err_ff ? '0 : pos_round(v3_ppy_ff);
         v4_pz_ff   <= v3_err_ff ? '0 : pos_round(v3_ppz_ff);
         v4_nx_ff   <= v3_err_ff ? '0 : v3_nx_ff;
         v4_ny_ff   <= v3_err_ff ? '0 : v3_ny_ff;
         v4_nz_ff   <= v3_err_ff ? '0 : v3_nz_ff;
         v4_tu_ff   <= v3_err_ff ? '0 : v3_tu_ff;
         v4_tv_ff   <= v3_err_ff ? '0 : v3_tv_ff;
         v4_last_ff <= v3_last_ff;
         v4_err_ff  <= v3_err_ff;
      end
   end

   assign rsp.valid       = v4_vld_ff;
   assign rsp.pos_x       = v4_px_ff;
   assign rsp.pos_y       = v4_py_ff;
   assign rsp.pos_z       = v4_pz_ff;
   assign rsp.norm_x      = v4_nx_ff;
   assign rsp.norm_y      = v4_ny_ff;
   assign rsp.norm_z      = v4_nz_ff;
   assign rsp.tex_u       = v4_tu_ff;
   assign rsp.tex_v       = v4_tv_ff;
   assign rsp.last_vertex = v4_last_ff;
   assign rsp.index_error = v4_err_ff;

endmodule

// ----- hdl/uv_sphere_cell_vertices_unit.sv -----
// ----------------------------------------------------------------------------
// uv_sphere_cell_vertices_unit
// Uv sphere tessellator: one grid cell in, its two triangles out as six
// vertices with position, normal and texture coordinates.
// ----------------------------------------------------------------------------
// One cell is taken per transfer and answered with six vertex transfers; the
// response port moves one vertex per cycle while its ready is high, and the
// walker takes the next cell as the last vertex of the current one moves on.
// From the input register to the first vertex lie a 41-stage divider for
// the angles and texture coordinates, a CORDIC_STEPS + 2 stage cordic, the
// corner walker register and four vertex stages. While the last vertices of
// one cell drain, the next cells keep moving through the divider and cordic
// pipelines until a finished cell reaches their end and waits on the walker.
module uv_sphere_cell_vertices_unit #(
   parameter int MAX_DIVISIONS = 256,
   parameter int CORDIC_STEPS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   uvs_req_if.sink              req_chan,
   uvs_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  uvs_pkg::csr_idx_type csr_index,
   input  logic [22:0]          csr_wdata
);

   localparam int DIV_LAT = uvs_pkg::DIV_NUM_W;
   localparam int COR_LAT = CORDIC_STEPS + 2;
   localparam int LAT     = DIV_LAT + COR_LAT;
   localparam int NW      = uvs_pkg::DIV_NUM_W;
   localparam int DW      = uvs_pkg::DIV_DEN_W;

   logic [22:0]           radius_ff;
   logic [8:0]            slice_cnt_ff;
   logic [8:0]            stack_cnt_ff;
   logic [8:0]            ns, nt;
   logic                  f0_vld_ff;
   logic [7:0]            f0_i_ff, f0_j_ff;
   logic                  f0_err;
   logic [8:0]            ki [2];
   logic [8:0]            kj [2];
   logic [NW-1:0]         num_lane [8];
   logic [DW-1:0]         den_lane [8];
   logic [NW-1:0]         quo_lane [8];
   logic signed [31:0]    cos_lane [4];
   logic signed [31:0]    sin_lane [4];
   logic                  side_vld_ff [LAT];
   logic                  side_err_ff [LAT];
   logic [3:0][16:0]      tex_now;
   logic [3:0][16:0]      tex_dly_ff [COR_LAT];
   logic                  front_last_vld;
   logic                  ser_ready;
   logic                  en_front;
   uvs_pkg::vtx_item_type item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= 23'd65536;
         slice_cnt_ff <= 9'd16;
         stack_cnt_ff <= 9'd16;
      end else if (csr_we) begin
         unique case (csr_index)
            uvs_pkg::CSR_RADIUS: radius_ff    <= csr_wdata;
            uvs_pkg::CSR_SLICES: slice_cnt_ff <= csr_wdata[8:0];
            uvs_pkg::CSR_STACKS: stack_cnt_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   assign ns = (slice_cnt_ff > MAX_DIVISIONS) ? 9'(MAX_DIVISIONS) : slice_cnt_ff;
   assign nt = (stack_cnt_ff > MAX_DIVISIONS) ? 9'(MAX_DIVISIONS) : stack_cnt_ff;

   // the front pipeline moves unless a finished cell waits on a busy walker
   assign front_last_vld = side_vld_ff[LAT-1];
   assign en_front       = !front_last_vld || ser_ready;
   assign req_chan.ready = en_front;

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_vld_ff <= 1'b0;
         for (int k = 0; k < LAT; k++) side_vld_ff[k] <= 1'b0;
      end else if (en_front) begin
         f0_vld_ff      <= req_chan.valid;
         side_vld_ff[0] <= f0_vld_ff;
         for (int k = 1; k < LAT; k++) side_vld_ff[k] <= side_vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en_front) begin
         f0_i_ff        <= req_chan.slice_index;
         f0_j_ff        <= req_chan.stack_index;
         side_err_ff[0] <= f0_err;
         for (int k = 1; k < LAT; k++) side_err_ff[k] <= side_err_ff[k-1];
         tex_dly_ff[0] <= tex_now;
         for (int k = 1; k < COR_LAT; k++) tex_dly_ff[k] <= tex_dly_ff[k-1];
      end
   end

   assign f0_err = (ns == 9'd0) || (nt == 9'd0) || ({1'b0, f0_i_ff} >= ns)
                   || ({1'b0, f0_j_ff} >= nt);

   // dividends are built by placement: the bias terms never reach the index bits
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         ki[a] = {1'b0, f0_i_ff} + 9'(a);
         kj[a] = {1'b0, f0_j_ff} + 9'(a);
         num_lane[a]   = {ki[a], 23'b0, ns};
         den_lane[a]   = {ns, 1'b0};
         num_lane[2+a] = {kj[a], 24'b0, nt[8:1]};
         den_lane[2+a] = {1'b0, nt};
         num_lane[4+a] = {16'b0, ki[a], 8'b0, ns[8:1]};
         den_lane[4+a] = {1'b0, ns};
         num_lane[6+a] = {16'b0, kj[a], 8'b0, nt[8:1]};
         den_lane[6+a] = {1'b0, nt};
      end
   end

   for (genvar l = 0; l < 8; l++) begin : g_div
      uvs_div #(.NW(NW), .DW(DW)) u_div (
         .clock (clock),
         .en    (en_front),
         .num   (num_lane[l]),
         .den   (den_lane[l]),
         .quo   (quo_lane[l])
      );
   end

   for (genvar l = 0; l < 4; l++) begin : g_cordic
      uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
         .clock   (clock),
         .en      (en_front),
         .ang     (quo_lane[l][31:0]),
         .cos_out (cos_lane[l]),
         .sin_out (sin_lane[l])
      );
   end

   assign tex_now = {quo_lane[7][16:0], quo_lane[6][16:0],
                     quo_lane[5][16:0], quo_lane[4][16:0]};

   assign item.th_c = {cos_lane[1], cos_lane[0]};
   assign item.th_s = {sin_lane[1], sin_lane[0]};
   assign item.ph_c = {cos_lane[3], cos_lane[2]};
   assign item.ph_s = {sin_lane[3], sin_lane[2]};
   assign item.tv   = {tex_dly_ff[COR_LAT-1][1], tex_dly_ff[COR_LAT-1][0]};
   assign item.tu   = {tex_dly_ff[COR_LAT-1][3], tex_dly_ff[COR_LAT-1][2]};
   assign item.err  = side_err_ff[LAT-1];

   uvs_vertex u_vertex (
      .clock    (clock),
      .reset    (reset),
      .ld_valid (front_last_vld),
      .ld_ready (ser_ready),
      .item     (item),
      .radius   (radius_ff),
      .rsp      (rsp_chan)
   );

   // a bad cell carries nothing but its flags (sampled on pos_x, norm_y and tex_v)
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.index_error |->
         rsp_chan.pos_x == 24'sd0 && rsp_chan.norm_y == 16'sd0 && rsp_chan.tex_v == 17'd0)
      else $error("vertex of a bad cell has nonzero payload");

   // a finished cell held back by the walker stays put
   assert property (@(posedge clock) disable iff (reset)
      front_last_vld && !ser_ready |=> front_last_vld && $stable(item.err))
      else $error("finished cell lost while walker busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.tex_u <= 17'd65536 && rsp_chan.tex_v <= 17'd65536)
      else $error("texture coordinate above one");

endmodule
